// File: rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 64;
    localparam int PRI_W  = 64;
    localparam int ICNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
    } t_slot;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            slot;
    } t_mem_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
        t_status           status;
        logic [ICNT_W-1:0] count;
        logic              empty;
        logic              full;
    } t_result;

endpackage

// File: rtl/min_priority_queue.sv
`timescale 1ns / 1ps
// Insert and rejected requests go from idle straight to the result state; extract and peek
//   first pass through the scan state, which reads all count slots (count = items stored, 16 when full).
// A new request is taken only when idle, after the last result went to the output register;
//   the scan uses the single slot-RAM read port, one slot compared per cycle by one 64-bit comparator.
// Reset (synchronous, active low on i_rst_n) empties the queue at once; slot storage is not
//   cleared, since only slots below the count are ever read.

module min_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [mpq_pkg::DATA_W-1:0]  i_item_data,
    input  logic [mpq_pkg::PRI_W-1:0]   i_item_priority,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mpq_pkg::DATA_W-1:0]  o_out_data,
    output logic [mpq_pkg::PRI_W-1:0]   o_out_priority,
    output logic [1:0]                  o_status,
    output logic [mpq_pkg::ICNT_W-1:0]  o_item_count,
    output logic                        o_is_empty,
    output logic                        o_is_full
);

    // Sequencer <-> slot RAM
    mpq_pkg::t_mem_wr  mem_wr;
    mpq_pkg::t_mem_rd  mem_rd;
    mpq_pkg::t_slot    mem_rd_data;

    // Sequencer result handshake into the output register
    logic              res_valid;
    logic              res_ready;
    mpq_pkg::t_result  res;

    // Output register: holds a finished result while the sequencer moves on to the next request
    logic              r_out_vld, n_out_vld;
    mpq_pkg::t_result  r_out, n_out;

    mpq_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd      (mem_rd),
        .o_rd_data (mem_rd_data)
    );

    mpq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_op        (mpq_pkg::t_op'(i_operation)),
        .i_data      (i_item_data),
        .i_pri       (i_item_priority),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_wr    (mem_wr),
        .o_mem_rd    (mem_rd),
        .i_rd_data   (mem_rd_data)
    );

    // Take a new result when the register is empty or being drained this cycle
    assign res_ready = !r_out_vld || i_ready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (res_ready) begin
            n_out_vld = res_valid;
            if (res_valid) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

    assign o_valid        = r_out_vld;
    assign o_out_data     = r_out.data;
    assign o_out_priority = r_out.pri;
    assign o_status       = r_out.status;
    assign o_item_count   = r_out.count;
    assign o_is_empty     = r_out.empty;
    assign o_is_full      = r_out.full;

endmodule

// File: rtl/mpq_slot_ram.sv
`timescale 1ns / 1ps

module mpq_slot_ram (
    input  logic                     i_clk,
    input  mpq_pkg::t_mem_wr         i_wr,
    input  mpq_pkg::t_mem_rd         i_rd,
    output mpq_pkg::t_slot           o_rd_data
);

    mpq_pkg::t_slot r_mem [mpq_pkg::DEPTH];
    mpq_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.slot;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/mpq_seq.sv
`timescale 1ns / 1ps

module mpq_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  mpq_pkg::t_op                  i_op,
    input  logic [mpq_pkg::DATA_W-1:0]    i_data,
    input  logic [mpq_pkg::PRI_W-1:0]     i_pri,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output mpq_pkg::t_result              o_res,
    output mpq_pkg::t_mem_wr              o_mem_wr,
    output mpq_pkg::t_mem_rd              o_mem_rd,
    input  mpq_pkg::t_slot                i_rd_data
);

    mpq_pkg::t_state                 r_state, n_state;
    logic [mpq_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            r_rd_vld, n_rd_vld;
    mpq_pkg::t_op                    r_op, n_op;
    logic [mpq_pkg::CNT_W-1:0]       r_rd_cnt, n_rd_cnt;
    logic [mpq_pkg::IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    mpq_pkg::t_slot                  r_best, n_best;
    logic [mpq_pkg::IDX_W-1:0]       r_best_idx, n_best_idx;
    mpq_pkg::t_slot                  r_res, n_res;
    mpq_pkg::t_status                r_res_status, n_res_status;

    logic                            is_full;
    logic                            take;
    mpq_pkg::t_slot                  cand_best;
    logic [mpq_pkg::IDX_W-1:0]       cand_idx;
    logic [mpq_pkg::IDX_W-1:0]       last_idx;
    logic                            scan_last;

    assign is_full   = (r_count == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
    // first arrival seeds the minimum; later ones replace it only when strictly smaller
    assign take      = (r_cmp_idx == '0) || (i_rd_data.pri < r_best.pri);
    assign cand_best = take ? i_rd_data : r_best;
    assign cand_idx  = take ? r_cmp_idx : r_best_idx;
    assign last_idx  = mpq_pkg::IDX_W'(r_count - 1'b1);
    assign scan_last = (r_state == mpq_pkg::ST_SCAN) && r_rd_vld && (r_cmp_idx == last_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpq_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    if ((i_op == mpq_pkg::OP_EXTRACT || i_op == mpq_pkg::OP_PEEK) &&
                        (r_count != '0)) begin
                        n_state = mpq_pkg::ST_SCAN;
                    end else begin
                        n_state = mpq_pkg::ST_RESULT;
                    end
                end
            end
            mpq_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = mpq_pkg::ST_RESULT;
                end
            end
            mpq_pkg::ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = mpq_pkg::ST_IDLE;
                end
            end
            default: n_state = mpq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_rd_vld     = 1'b0;
        n_op         = r_op;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_idx    = r_cmp_idx;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_res        = r_res;
        n_res_status = r_res_status;
        o_mem_wr     = '0;
        o_mem_rd     = '0;
        o_req_ready  = (r_state == mpq_pkg::ST_IDLE);
        o_res_valid  = (r_state == mpq_pkg::ST_RESULT);

        unique case (r_state)
            mpq_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_op         = i_op;
                    n_res        = '0;
                    n_res_status = mpq_pkg::STAT_DONE;
                    n_rd_cnt     = '0;
                    unique case (i_op)
                        mpq_pkg::OP_INSERT: begin
                            if (is_full) begin
                                n_res_status = mpq_pkg::STAT_FULL;
                            end else begin
                                o_mem_wr.en        = 1'b1;
                                o_mem_wr.addr      = r_count[mpq_pkg::IDX_W-1:0];
                                o_mem_wr.slot.data = i_data;
                                o_mem_wr.slot.pri  = i_pri;
                                n_count            = r_count + 1'b1;
                            end
                        end
                        mpq_pkg::OP_EXTRACT, mpq_pkg::OP_PEEK: begin
                            if (r_count == '0) begin
                                n_res_status = mpq_pkg::STAT_EMPTY;
                            end
                        end
                        mpq_pkg::OP_NOP: begin
                        end
                    endcase
                end
            end
            mpq_pkg::ST_SCAN: begin
                // issue one slot read a cycle
                if (r_rd_cnt < r_count) begin
                    o_mem_rd.en   = 1'b1;
                    o_mem_rd.addr = r_rd_cnt[mpq_pkg::IDX_W-1:0];
                    n_rd_cnt      = r_rd_cnt + 1'b1;
                    n_cmp_idx     = r_rd_cnt[mpq_pkg::IDX_W-1:0];
                    n_rd_vld      = 1'b1;
                end
                // compare the slot read last cycle
                if (r_rd_vld) begin
                    n_best     = cand_best;
                    n_best_idx = cand_idx;
                end
                if (scan_last) begin
                    n_res = cand_best;
                    // the arriving slot is the last one: move it into the freed place
                    if (r_op == mpq_pkg::OP_EXTRACT) begin
                        o_mem_wr.en   = 1'b1;
                        o_mem_wr.addr = cand_idx;
                        o_mem_wr.slot = i_rd_data;
                        n_count       = r_count - 1'b1;
                    end
                end
            end
            mpq_pkg::ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mpq_pkg::ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
        r_op         <= n_op;
        r_rd_cnt     <= n_rd_cnt;
        r_cmp_idx    <= n_cmp_idx;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_res        <= n_res;
        r_res_status <= n_res_status;
    end

    assign o_res.data   = r_res.data;
    assign o_res.pri    = r_res.pri;
    assign o_res.status = r_res_status;
    assign o_res.count  = mpq_pkg::ICNT_W'(r_count);
    assign o_res.empty  = (r_count == '0);
    assign o_res.full   = is_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
        else $error("slot count above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpq_pkg::ST_IDLE && i_req_valid && i_op == mpq_pkg::OP_INSERT && !is_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance count");

    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpq_pkg::ST_SCAN && o_mem_wr.en) |-> (scan_last && r_op == mpq_pkg::OP_EXTRACT))
        else $error("slot write during scan outside the final extract move");

    a_no_scan_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpq_pkg::ST_SCAN) |-> (r_count != '0))
        else $error("scan running on an empty queue");

endmodule
